@@ rtl/ctb_pkg.sv @@
// Shared types and constants for the clipped transparent blit.
package ctb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 13;
    localparam int ORG_W      = 12;
    localparam int POS_W      = ((ORG_W > CNT_W) ? ORG_W : CNT_W) + 1;
    localparam int CMP_W      = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
    localparam int PROD_W     = POS_W + DIM_W;
    localparam int IDX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_WIDTH    = 3'd0,
        CFG_DEST_HEIGHT   = 3'd1,
        CFG_SOURCE_WIDTH  = 3'd2,
        CFG_SOURCE_HEIGHT = 3'd3,
        CFG_ORIGIN_X      = 3'd4,
        CFG_ORIGIN_Y      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] dest_width;
        logic [DIM_W-1:0] dest_height;
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] tx;
        logic [POS_W-1:0] ty;
        logic             img_end;
    } t_pos;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_pixel;

endpackage

@@ rtl/ctb_pix_if.sv @@
// Source pixel channel: valid/ready with one RGBA8 pixel.
interface ctb_pix_if;
    logic                     valid;
    logic                     ready;
    logic [ctb_pkg::CH_W-1:0] red;
    logic [ctb_pkg::CH_W-1:0] green;
    logic [ctb_pkg::CH_W-1:0] blue;
    logic [ctb_pkg::CH_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

@@ rtl/ctb_res_if.sv @@
// Result channel: valid/ready with destination index, pixel and flags.
interface ctb_res_if;
    logic                      valid;
    logic                      ready;
    logic                      write_enable;
    logic [ctb_pkg::IDX_W-1:0] dest_index;
    logic [ctb_pkg::CH_W-1:0]  out_red;
    logic [ctb_pkg::CH_W-1:0]  out_green;
    logic [ctb_pkg::CH_W-1:0]  out_blue;
    logic [ctb_pkg::CH_W-1:0]  out_alpha;
    logic                      image_done;

    modport source (output valid, write_enable, dest_index, out_red, out_green,
                     out_blue, out_alpha, image_done, input ready);
    modport sink   (input valid, write_enable, dest_index, out_red, out_green,
                     out_blue, out_alpha, image_done, output ready);
endinterface

@@ rtl/clipped_transparent_blit.sv @@
// Top level: clipped, alpha-skipping blit of a row-major RGBA8 stream.
// Each accepted pixel passes the input register, then the result register that drives o_res.
// Throughput: one pixel per cycle while no result is held; one result per pixel, held while o_res.ready is low.
// Path per pixel: one 13x13 multiply and add between the pixel and result registers.
// Reset (synchronous, i_rst_n low): counters cleared, pipeline emptied, registers
// set to dest 4096x4096, source 1x1, origin 0,0.
module clipped_transparent_blit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ctb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ctb_pix_if.sink                         i_pix,
    ctb_res_if.source                       o_res
);

    ctb_pkg::t_cfg r_cfg, n_cfg;
    ctb_pkg::t_pos pos;
    logic          acc;

    assign acc = i_pix.valid && i_pix.ready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (ctb_pkg::t_cfg_idx'(i_cfg_idx))
                ctb_pkg::CFG_DEST_WIDTH:    n_cfg.dest_width    = i_cfg_data;
                ctb_pkg::CFG_DEST_HEIGHT:   n_cfg.dest_height   = i_cfg_data;
                ctb_pkg::CFG_SOURCE_WIDTH:  n_cfg.source_width  = i_cfg_data;
                ctb_pkg::CFG_SOURCE_HEIGHT: n_cfg.source_height = i_cfg_data;
                ctb_pkg::CFG_ORIGIN_X:
                    n_cfg.origin_x = i_cfg_data[ctb_pkg::ORG_W-1:0];
                ctb_pkg::CFG_ORIGIN_Y:
                    n_cfg.origin_y = i_cfg_data[ctb_pkg::ORG_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width    <= ctb_pkg::DIM_W'(ctb_pkg::MAX_DIM);
            r_cfg.dest_height   <= ctb_pkg::DIM_W'(ctb_pkg::MAX_DIM);
            r_cfg.source_width  <= ctb_pkg::DIM_W'(1);
            r_cfg.source_height <= ctb_pkg::DIM_W'(1);
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ctb_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_acc   (acc),
        .o_pos   (pos)
    );

    ctb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pos   (pos),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );

endmodule

@@ rtl/ctb_pos.sv @@
// Source column/row counters and destination position of the next pixel.
module ctb_pos (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctb_pkg::t_cfg   i_cfg,
    input  logic            i_acc,
    output ctb_pkg::t_pos   o_pos
);

    logic [ctb_pkg::CNT_W-1:0] r_col, n_col;
    logic [ctb_pkg::CNT_W-1:0] r_row, n_row;
    logic                      row_end;
    logic                      img_end;

    always_comb begin
        row_end = ((ctb_pkg::DIM_W + 1)'(r_col) + 1'b1 >=
                   (ctb_pkg::DIM_W + 1)'(i_cfg.source_width)) ||
                  (r_col == ctb_pkg::CNT_W'(ctb_pkg::MAX_DIM - 1));
        img_end = row_end &&
                  (((ctb_pkg::DIM_W + 1)'(r_row) + 1'b1 >=
                    (ctb_pkg::DIM_W + 1)'(i_cfg.source_height)) ||
                   (r_row == ctb_pkg::CNT_W'(ctb_pkg::MAX_DIM - 1)));

        o_pos.tx      = ctb_pkg::POS_W'(i_cfg.origin_x) + ctb_pkg::POS_W'(r_col);
        o_pos.ty      = ctb_pkg::POS_W'(i_cfg.origin_y) + ctb_pkg::POS_W'(r_row);
        o_pos.img_end = img_end;

        n_col = r_col;
        n_row = r_row;
        if (i_acc) begin
            priority if (img_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_img_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && img_end) |=> (r_col == '0 && r_row == '0))
        else $error("counters not cleared after last pixel");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && row_end && !img_end) |=> (r_col == '0 && r_row == $past(r_row) + 1'b1))
        else $error("row did not advance at end of row");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_acc |=> (r_col == $past(r_col) && r_row == $past(r_row)))
        else $error("counters moved without a transfer");

endmodule

@@ rtl/ctb_dp.sv @@
// Pixel input register, clip/index logic and result register.
module ctb_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ctb_pkg::t_cfg i_cfg,
    input  ctb_pkg::t_pos i_pos,
    ctb_pix_if.sink       i_pix,
    ctb_res_if.source     o_res
);

    logic                        r_s1_valid, n_s1_valid;
    ctb_pkg::t_pixel             r_s1_pix;
    ctb_pkg::t_pos               r_s1_pos;
    logic                        r_out_valid, n_out_valid;
    logic                        r_we;
    logic [ctb_pkg::IDX_W-1:0]   r_idx;
    ctb_pkg::t_pixel             r_pix;
    logic                        r_done;

    logic                        s1_ready;
    logic                        out_ready;
    logic                        in_bounds;
    logic                        we;
    logic [ctb_pkg::PROD_W-1:0]  prod;
    logic [ctb_pkg::PROD_W:0]    idx_full;

    assign out_ready   = !r_out_valid || o_res.ready;
    assign s1_ready    = !r_s1_valid || out_ready;
    assign i_pix.ready = s1_ready;

    always_comb begin
        n_s1_valid  = s1_ready ? i_pix.valid : r_s1_valid;
        n_out_valid = out_ready ? r_s1_valid : r_out_valid;

        in_bounds = (ctb_pkg::CMP_W'(r_s1_pos.tx) < ctb_pkg::CMP_W'(i_cfg.dest_width)) &&
                    (ctb_pkg::CMP_W'(r_s1_pos.ty) < ctb_pkg::CMP_W'(i_cfg.dest_height));
        we        = in_bounds && (r_s1_pix.alpha != '0);

        prod     = ctb_pkg::PROD_W'(r_s1_pos.ty) * ctb_pkg::PROD_W'(i_cfg.dest_width);
        idx_full = (ctb_pkg::PROD_W + 1)'(prod) + (ctb_pkg::PROD_W + 1)'(r_s1_pos.tx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_pix <= '{red: i_pix.red, green: i_pix.green,
                          blue: i_pix.blue, alpha: i_pix.alpha};
            r_s1_pos <= i_pos;
        end
        if (out_ready) begin
            r_we   <= we;
            r_idx  <= we ? idx_full[ctb_pkg::IDX_W-1:0] : '0;
            r_pix  <= we ? r_s1_pix : '0;
            r_done <= r_s1_pos.img_end;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.write_enable = r_we;
    assign o_res.dest_index   = r_idx;
    assign o_res.out_red      = r_pix.red;
    assign o_res.out_green    = r_pix.green;
    assign o_res.out_blue     = r_pix.blue;
    assign o_res.out_alpha    = r_pix.alpha;
    assign o_res.image_done   = r_done;

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_we) |-> (r_idx == '0 && r_pix == '0))
        else $error("skipped result carries nonzero payload");

    a_we_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_we) |-> (r_pix.alpha != '0))
        else $error("write enabled for transparent pixel");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready) |=> r_out_valid)
        else $error("staged pixel lost");

endmodule

@@ test/clipped_transparent_blit_tb.sv @@
// Testbench for clipped_transparent_blit: directed rows, then random image phases.
module clipped_transparent_blit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_PIXELS = 1500;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic             write_enable;
        logic [IDX_W-1:0] dest_index;
        t_pixel           px;
        logic             image_done;
    } t_blit_write;

    typedef enum logic {ROW_PIXEL, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_pixel                px;
        bit                    typed;
        t_blit_write           result;
    } t_row;

    localparam t_blit_write SKIPPED_LAST = '{1'b0, '0, '0, 1'b1};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ctb_pix_if pix_bus ();
    ctb_res_if res_bus ();

    clipped_transparent_blit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_bus),
        .o_res      (res_bus)
    );

    t_cfg             blit_cfg = '{13'd4096, 13'd4096, 13'd1, 13'd1, 12'd0, 12'd0};
    logic [CNT_W-1:0] src_col  = '0;
    logic [CNT_W-1:0] src_row  = '0;
    t_blit_write      predicted_writes[$];
    t_row             rows[$];
    bit               row_typed  = 1'b0;
    t_blit_write      row_result = '0;
    int               images_predicted = 0;
    int               mismatches = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Destination write for one source pixel; advances the source position.
    function automatic t_blit_write place_pixel(t_pixel px);
        t_blit_write w;
        int unsigned tx;
        int unsigned ty;
        logic [47:0] lin;
        logic        row_end;
        logic        img_end;
        tx = 32'(blit_cfg.origin_x) + 32'(src_col);
        ty = 32'(blit_cfg.origin_y) + 32'(src_row);
        row_end = (32'(src_col) + 1 >= 32'(blit_cfg.source_width)) ||
                  (32'(src_col) >= MAX_DIM - 1);
        img_end = row_end && ((32'(src_row) + 1 >= 32'(blit_cfg.source_height)) ||
                              (32'(src_row) >= MAX_DIM - 1));
        w = '0;
        if (tx < 32'(blit_cfg.dest_width) && ty < 32'(blit_cfg.dest_height) &&
            px.alpha != '0) begin
            lin = 48'(tx) + 48'(ty) * 48'(blit_cfg.dest_width);
            w.write_enable = 1'b1;
            w.dest_index   = lin[IDX_W-1:0];
            w.px           = px;
        end
        w.image_done = img_end;
        if (img_end) begin
            src_col = '0;
            src_row = '0;
        end else if (row_end) begin
            src_col = '0;
            src_row = src_row + 1'b1;
        end else begin
            src_col = src_col + 1'b1;
        end
        return w;
    endfunction

    function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEST_WIDTH:    blit_cfg.dest_width    = data;
            CFG_DEST_HEIGHT:   blit_cfg.dest_height   = data;
            CFG_SOURCE_WIDTH:  blit_cfg.source_width  = data;
            CFG_SOURCE_HEIGHT: blit_cfg.source_height = data;
            CFG_ORIGIN_X:      blit_cfg.origin_x      = data[ORG_W-1:0];
            CFG_ORIGIN_Y:      blit_cfg.origin_y      = data[ORG_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [IDX_W-1:0] want,
                                        logic [IDX_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_blit_write want;
        t_blit_write got;
        if (i_rst_n) begin
            if (pix_bus.valid && pix_bus.ready === 1'b1) begin
                want = place_pixel({pix_bus.red, pix_bus.green, pix_bus.blue, pix_bus.alpha});
                if (want.image_done)
                    images_predicted++;
                predicted_writes.push_back(row_typed ? row_result : want);
            end
            if (res_bus.ready && res_bus.valid !== 1'b0) begin
                got = {res_bus.write_enable, res_bus.dest_index, res_bus.out_red,
                       res_bus.out_green, res_bus.out_blue, res_bus.out_alpha,
                       res_bus.image_done};
                if (predicted_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got %0h", $time, got);
                end else begin
                    want = predicted_writes.pop_front();
                    check_field("write_enable", IDX_W'(want.write_enable),
                                IDX_W'(got.write_enable));
                    check_field("dest_index", want.dest_index, got.dest_index);
                    check_field("out_red", IDX_W'(want.px.red), IDX_W'(got.px.red));
                    check_field("out_green", IDX_W'(want.px.green), IDX_W'(got.px.green));
                    check_field("out_blue", IDX_W'(want.px.blue), IDX_W'(got.px.blue));
                    check_field("out_alpha", IDX_W'(want.px.alpha), IDX_W'(got.px.alpha));
                    check_field("image_done", IDX_W'(want.image_done),
                                IDX_W'(got.image_done));
                end
            end
        end
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(9, 24);
    endfunction

    initial begin
        int left;
        res_bus.ready = 1'b0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left > 0) begin
                left--;
            end else begin
                res_bus.ready = !res_bus.ready;
                if (res_bus.ready)
                    left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(0, 5);
                else
                    left = idle_cycles();
            end
        end
    end

    function automatic logic [CH_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim(int small_hi);
        case ($urandom_range(0, 29))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'(MAX_DIM);
            3:       return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 8191));
            4:       return CFG_DATA_W'($urandom);
            5:       return CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom_range(1, small_hi));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_origin();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_DATA_W'(MAX_DIM - 1);
            2:       return CFG_DATA_W'($urandom);
            3:       return CFG_DATA_W'($urandom_range(MAX_DIM - 8, MAX_DIM - 1));
            default: return CFG_DATA_W'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic void row_px(t_pixel px, bit typed = 1'b0, t_blit_write result = '0);
        rows.push_back('{ROW_PIXEL, '0, '0, px, typed, result});
    endfunction

    function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        rows.push_back('{ROW_REG, idx, data, '0, 1'b0, '0});
    endfunction

    task automatic send_pixel(t_pixel px, bit typed, t_blit_write result, bit steady);
        int gap;
        gap = steady ? 0 : idle_cycles();
        i_cfg_we = 1'b0;
        if (gap > 0) begin
            pix_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_bus.valid = 1'b1;
        {pix_bus.red, pix_bus.green, pix_bus.blue, pix_bus.alpha} = px;
        row_typed  = typed;
        row_result = result;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        pix_bus.valid = 1'b0;
        while (predicted_writes.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        load_reg(idx, data);
        @(negedge i_clk);
    endtask

    initial begin
        int sent;
        int sent_total;
        int want;
        int cap;
        int start;
        bit steady;
        logic [CH_W-1:0] alpha;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        pix_bus.alpha = '0;

        // after reset: 1x1 source at the origin of a 4096x4096 destination
        row_px(t_pixel'(32'hffffffff), 1'b1, '{1'b1, '0, t_pixel'(32'hffffffff), 1'b1});
        row_px(t_pixel'(32'h12345600), 1'b1, SKIPPED_LAST);
        row_px(t_pixel'(32'h00000001), 1'b1, '{1'b1, '0, t_pixel'(32'h00000001), 1'b1});
        // zero destination sizes clip everything
        row_reg(CFG_DEST_WIDTH, '0);
        row_px(t_pixel'(32'haa55aaff), 1'b1, SKIPPED_LAST);
        row_reg(CFG_DEST_WIDTH, CFG_DATA_W'(MAX_DIM));
        row_reg(CFG_DEST_HEIGHT, '0);
        row_px(t_pixel'(32'h55aa55ff), 1'b1, SKIPPED_LAST);
        // zero source sizes act as 1x1
        row_reg(CFG_DEST_HEIGHT, CFG_DATA_W'(MAX_DIM));
        row_reg(CFG_SOURCE_WIDTH, '0);
        row_reg(CFG_SOURCE_HEIGHT, '0);
        row_px(t_pixel'(32'h01020304), 1'b1, '{1'b1, '0, t_pixel'(32'h01020304), 1'b1});
        // 3x2 image straddling the right edge; spare indexes must be ignored
        row_reg(CFG_SOURCE_WIDTH, 13'd3);
        row_reg(CFG_SOURCE_HEIGHT, 13'd2);
        row_reg(CFG_ORIGIN_X, 13'd4094);
        row_reg(CFG_ORIGIN_Y, 13'd1);
        row_reg(CFG_SPARE_LO, '0);
        row_reg(CFG_SPARE_HI, '0);
        row_px(t_pixel'(32'h10203040));
        row_px(t_pixel'(32'h50607000));
        row_px(t_pixel'(32'h8090a0b0));
        row_px(t_pixel'(32'hc0d0e0f0));
        row_px(t_pixel'(32'h0f1e2d3c));
        row_px(t_pixel'(32'h4b5a6978));
        // oversized registers: index wraps to 24 bits, origin keeps 12 bits
        row_reg(CFG_DEST_WIDTH, '1);
        row_reg(CFG_DEST_HEIGHT, '1);
        row_reg(CFG_ORIGIN_X, '1);
        row_reg(CFG_ORIGIN_Y, CFG_DATA_W'(MAX_DIM - 1));
        row_reg(CFG_SOURCE_WIDTH, 13'd1);
        row_reg(CFG_SOURCE_HEIGHT, 13'd1);
        row_px(t_pixel'(32'hc0ffee80));
        row_px(t_pixel'(32'h80808000), 1'b1, SKIPPED_LAST);
        // 2x2 source into a 1x1 destination
        row_reg(CFG_DEST_WIDTH, 13'd1);
        row_reg(CFG_DEST_HEIGHT, 13'd1);
        row_reg(CFG_ORIGIN_X, '0);
        row_reg(CFG_ORIGIN_Y, '0);
        row_reg(CFG_SOURCE_WIDTH, 13'd2);
        row_reg(CFG_SOURCE_HEIGHT, 13'd2);
        row_px(t_pixel'(32'h11223344));
        row_px(t_pixel'(32'h55667788));
        row_px(t_pixel'(32'h99aabbcc));
        row_px(t_pixel'(32'hddeeff01));

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[n]) begin
            if (rows[n].kind == ROW_REG) begin
                if (n == 0 || rows[n-1].kind == ROW_PIXEL)
                    go_idle();
                write_reg(rows[n].reg_idx, rows[n].reg_data);
            end else begin
                send_pixel(rows[n].px, rows[n].typed, rows[n].result, 1'b0);
            end
        end

        sent_total = 0;
        while (sent_total < RANDOM_PIXELS) begin
            go_idle();
            for (int k = CFG_DEST_WIDTH; k <= CFG_ORIGIN_Y; k++) begin
                if ($urandom_range(0, 2) != 0) begin
                    case (t_cfg_idx'(k))
                        CFG_DEST_WIDTH, CFG_DEST_HEIGHT:
                            write_reg(CFG_IDX_W'(k), pick_dim(16));
                        CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT:
                            write_reg(CFG_IDX_W'(k), pick_dim(8));
                        default:
                            write_reg(CFG_IDX_W'(k), pick_origin());
                    endcase
                end
            end
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          CFG_DATA_W'($urandom));
            want   = $urandom_range(1, 3);
            cap    = 48;
            steady = ($urandom_range(0, 4) == 0);
            start  = images_predicted;
            sent   = 0;
            while (images_predicted - start < want && sent < cap) begin
                alpha = ($urandom_range(0, 3) == 0) ? '0 : rand_byte();
                send_pixel({rand_byte(), rand_byte(), rand_byte(), alpha}, 1'b0, '0, steady);
                sent++;
            end
            sent_total += sent;
        end

        go_idle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("clipped_transparent_blit verification clean");
        else
            $display("clipped_transparent_blit verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("clipped_transparent_blit verification failed");
        $finish;
    end

endmodule
